>>> src/dlf_pkg.sv
package dlf_pkg;

	localparam int LINE_MAX = 64;
	localparam int IDX_W    = $clog2(LINE_MAX);
	localparam int CNT_W    = $clog2(LINE_MAX + 1);
	localparam int COEF_W   = 18;
	localparam int SMP_W    = 16;
	localparam int VAL_W    = 32;
	localparam int OPD_W    = 33;
	localparam int ACC_W    = 53;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_SUB  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_A0   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_A1   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_A2   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_A3   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_B1   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_B2   = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_GAIN = 3'd7;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CMAC,
		S_CWR,
		S_ARD,
		S_AGET,
		S_AMAC,
		S_AWR,
		S_ERD,
		S_EMAC,
		S_EOUT,
		S_EWAIT
	} state_t;

	typedef struct packed {
		logic en;
		logic clr;
	} mac_ctrl_t;

	function automatic logic signed [VAL_W-1:0] rnd_q16(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W:0] t;
		logic signed [ACC_W:0] r;
		t = {acc[ACC_W-1], acc} + (ACC_W+1)'(32768);
		r = t >>> 16;
		if (r > (ACC_W+1)'(64'sh7fffffff))
			return {1'b0, {(VAL_W-1){1'b1}}};
		else if (r < -(ACC_W+1)'(64'sh80000000))
			return {1'b1, {(VAL_W-1){1'b0}}};
		else
			return r[VAL_W-1:0];
	endfunction

	function automatic logic signed [SMP_W-1:0] rnd_out(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W:0] t;
		logic signed [ACC_W:0] r;
		t = {acc[ACC_W-1], acc} + (ACC_W+1)'(64'h80000000);
		r = t >>> 32;
		if (r > (ACC_W+1)'(32767))
			return 16'sh7fff;
		else if (r < -(ACC_W+1)'(32768))
			return 16'sh8000;
		else
			return r[SMP_W-1:0];
	endfunction

endpackage

>>> src/deriche_line_filter.sv
// Second-order recursive line filter, Q2.16 coefficients. Samples are taken one
// at a time; the first two of a line are only stored, each later one waits
// while the causal recursion runs its four terms through one shared
// multiply-accumulate unit. After the sample marked last the block is busy:
// the anticausal pass runs back over the line (the MAC skips the last two
// samples), then each result is scaled by the gain and held until out_ready.
// Lines over 64 samples are cut to 64 and every result carries line_truncated.
module deriche_line_filter (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [dlf_pkg::SMP_W-1:0]      sample,
	input  logic                                  last_in_line,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [dlf_pkg::SMP_W-1:0]      filtered,
	output logic                                  last_out,
	output logic                                  line_truncated,
	input  logic                                  cfg_we,
	input  logic [dlf_pkg::REG_IDX_W-1:0]         cfg_index,
	input  logic [dlf_pkg::COEF_W-1:0]            cfg_data
);

	dlf_pkg::state_t state_q, state_d;

	logic                                sub_q;
	logic signed [dlf_pkg::COEF_W-1:0]   a0_q, a1_q, a2_q, a3_q, b1_q, b2_q, gain_q;

	logic [dlf_pkg::CNT_W-1:0]           cnt_q;
	logic                                trunc_q;
	logic                                last_q;
	logic [dlf_pkg::IDX_W-1:0]           k_q;
	logic [1:0]                          step_q;

	logic signed [dlf_pkg::SMP_W-1:0]    x_q, xprev_q, xk_q, xp1_q, xp2_q;
	logic signed [dlf_pkg::VAL_W-1:0]    c1_q, c2_q, im1_q, im2_q;

	logic signed [dlf_pkg::SMP_W-1:0]    smp_mem [dlf_pkg::LINE_MAX];
	logic signed [dlf_pkg::VAL_W-1:0]    cau_mem [dlf_pkg::LINE_MAX];
	logic signed [dlf_pkg::VAL_W-1:0]    anti_mem [dlf_pkg::LINE_MAX];
	logic signed [dlf_pkg::SMP_W-1:0]    smp_rd_q;
	logic signed [dlf_pkg::VAL_W-1:0]    cau_rd_q, anti_rd_q;

	logic                                out_valid_q;
	logic signed [dlf_pkg::SMP_W-1:0]    filt_q;
	logic                                last_out_q, trunc_out_q;

	dlf_pkg::mac_ctrl_t                  mac_ctrl;
	logic signed [dlf_pkg::COEF_W-1:0]   mac_coef;
	logic signed [dlf_pkg::OPD_W-1:0]    mac_opd;
	logic signed [dlf_pkg::ACC_W-1:0]    mac_acc;

	logic                                in_acc;
	logic                                room;
	logic                                edge_k;
	logic                                k_last;
	logic signed [dlf_pkg::VAL_W-1:0]    rnd_v;
	logic signed [dlf_pkg::VAL_W-1:0]    xk_v;
	logic signed [dlf_pkg::VAL_W-1:0]    smp_v;

	assign in_ready  = (state_q == dlf_pkg::S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign room      = (cnt_q < dlf_pkg::CNT_W'(dlf_pkg::LINE_MAX));
	assign edge_k    = ({1'b0, k_q} + dlf_pkg::CNT_W'(2)) >= cnt_q;
	assign k_last    = ({1'b0, k_q} + dlf_pkg::CNT_W'(1)) == cnt_q;
	assign rnd_v     = dlf_pkg::rnd_q16(mac_acc);
	assign xk_v      = {smp_rd_q, 16'h0000};
	assign smp_v     = {sample, 16'h0000};

	dlf_mac u_mac (
		.clk  (clk),
		.ctrl (mac_ctrl),
		.coef (mac_coef),
		.opd  (mac_opd),
		.acc  (mac_acc)
	);

	always_comb begin
		mac_ctrl = '{en: 1'b0, clr: 1'b0};
		mac_coef = gain_q;
		mac_opd  = sub_q ? (dlf_pkg::OPD_W'(cau_rd_q) - dlf_pkg::OPD_W'(anti_rd_q))
		                 : (dlf_pkg::OPD_W'(cau_rd_q) + dlf_pkg::OPD_W'(anti_rd_q));
		case (state_q)
			dlf_pkg::S_CMAC: begin
				mac_ctrl = '{en: 1'b1, clr: (step_q == 2'd0)};
				case (step_q)
					2'd0: begin
						mac_coef = a0_q;
						mac_opd  = dlf_pkg::OPD_W'($signed({x_q, 16'h0000}));
					end
					2'd1: begin
						mac_coef = a1_q;
						mac_opd  = dlf_pkg::OPD_W'($signed({xprev_q, 16'h0000}));
					end
					2'd2: begin mac_coef = b1_q; mac_opd = dlf_pkg::OPD_W'(c1_q); end
					default: begin mac_coef = b2_q; mac_opd = dlf_pkg::OPD_W'(c2_q); end
				endcase
			end
			dlf_pkg::S_AMAC: begin
				mac_ctrl = '{en: 1'b1, clr: (step_q == 2'd0)};
				case (step_q)
					2'd0: begin
						mac_coef = a2_q;
						mac_opd  = dlf_pkg::OPD_W'($signed({xp1_q, 16'h0000}));
					end
					2'd1: begin
						mac_coef = a3_q;
						mac_opd  = dlf_pkg::OPD_W'($signed({xp2_q, 16'h0000}));
					end
					2'd2: begin mac_coef = b1_q; mac_opd = dlf_pkg::OPD_W'(im1_q); end
					default: begin mac_coef = b2_q; mac_opd = dlf_pkg::OPD_W'(im2_q); end
				endcase
			end
			dlf_pkg::S_EMAC: begin
				mac_ctrl = '{en: 1'b1, clr: 1'b1};
			end
			default: begin
				mac_ctrl = '{en: 1'b0, clr: 1'b0};
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dlf_pkg::S_IDLE: begin
				if (in_acc) begin
					if (room && (cnt_q >= dlf_pkg::CNT_W'(2)))
						state_d = dlf_pkg::S_CMAC;
					else if (last_in_line)
						state_d = dlf_pkg::S_ARD;
				end
			end
			dlf_pkg::S_CMAC: if (step_q == 2'd3) state_d = dlf_pkg::S_CWR;
			dlf_pkg::S_CWR:  state_d = last_q ? dlf_pkg::S_ARD : dlf_pkg::S_IDLE;
			dlf_pkg::S_ARD:  state_d = dlf_pkg::S_AGET;
			dlf_pkg::S_AGET: begin
				if (!edge_k)
					state_d = dlf_pkg::S_AMAC;
				else if (k_q == '0)
					state_d = dlf_pkg::S_ERD;
				else
					state_d = dlf_pkg::S_ARD;
			end
			dlf_pkg::S_AMAC: if (step_q == 2'd3) state_d = dlf_pkg::S_AWR;
			dlf_pkg::S_AWR:  state_d = (k_q == '0) ? dlf_pkg::S_ERD : dlf_pkg::S_ARD;
			dlf_pkg::S_ERD:  state_d = dlf_pkg::S_EMAC;
			dlf_pkg::S_EMAC: state_d = dlf_pkg::S_EOUT;
			dlf_pkg::S_EOUT: state_d = dlf_pkg::S_EWAIT;
			dlf_pkg::S_EWAIT: begin
				if (out_ready)
					state_d = k_last ? dlf_pkg::S_IDLE : dlf_pkg::S_ERD;
			end
			default: state_d = dlf_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlf_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q  <= 1'b0;
			a0_q   <= '0;
			a1_q   <= 18'sd65536;
			a2_q   <= 18'sd65536;
			a3_q   <= '0;
			b1_q   <= '0;
			b2_q   <= '0;
			gain_q <= 18'sd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				dlf_pkg::REG_SUB:  sub_q  <= cfg_data[0];
				dlf_pkg::REG_A0:   a0_q   <= cfg_data;
				dlf_pkg::REG_A1:   a1_q   <= cfg_data;
				dlf_pkg::REG_A2:   a2_q   <= cfg_data;
				dlf_pkg::REG_A3:   a3_q   <= cfg_data;
				dlf_pkg::REG_B1:   b1_q   <= cfg_data;
				dlf_pkg::REG_B2:   b2_q   <= cfg_data;
				dlf_pkg::REG_GAIN: gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			trunc_q     <= 1'b0;
			last_q      <= 1'b0;
			k_q         <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				dlf_pkg::S_IDLE: begin
					step_q <= '0;
					if (in_acc) begin
						last_q <= last_in_line;
						if (room) begin
							if (cnt_q < dlf_pkg::CNT_W'(2))
								cnt_q <= cnt_q + dlf_pkg::CNT_W'(1);
							k_q <= cnt_q[dlf_pkg::IDX_W-1:0];
						end else begin
							trunc_q <= 1'b1;
							k_q     <= dlf_pkg::IDX_W'(dlf_pkg::LINE_MAX - 1);
						end
					end
				end
				dlf_pkg::S_CMAC: step_q <= step_q + 2'd1;
				dlf_pkg::S_CWR:  cnt_q <= cnt_q + dlf_pkg::CNT_W'(1);
				dlf_pkg::S_AGET: begin
					step_q <= '0;
					if (edge_k && (k_q != '0))
						k_q <= k_q - dlf_pkg::IDX_W'(1);
				end
				dlf_pkg::S_AMAC: step_q <= step_q + 2'd1;
				dlf_pkg::S_AWR:  if (k_q != '0) k_q <= k_q - dlf_pkg::IDX_W'(1);
				dlf_pkg::S_EOUT: out_valid_q <= 1'b1;
				dlf_pkg::S_EWAIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (k_last) begin
							cnt_q   <= '0;
							trunc_q <= 1'b0;
							k_q     <= '0;
						end else begin
							k_q <= k_q + dlf_pkg::IDX_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			dlf_pkg::S_IDLE: begin
				if (in_acc && room) begin
					x_q <= sample;
					if (cnt_q < dlf_pkg::CNT_W'(2)) begin
						xprev_q <= sample;
						c2_q    <= c1_q;
						c1_q    <= smp_v;
					end
				end
			end
			dlf_pkg::S_CWR: begin
				xprev_q <= x_q;
				c2_q    <= c1_q;
				c1_q    <= rnd_v;
			end
			dlf_pkg::S_AGET: begin
				xk_q <= smp_rd_q;
				if (edge_k) begin
					xp2_q <= xp1_q;
					xp1_q <= smp_rd_q;
					im2_q <= im1_q;
					im1_q <= xk_v;
				end
			end
			dlf_pkg::S_AWR: begin
				xp2_q <= xp1_q;
				xp1_q <= xk_q;
				im2_q <= im1_q;
				im1_q <= rnd_v;
			end
			dlf_pkg::S_EOUT: begin
				filt_q      <= dlf_pkg::rnd_out(mac_acc);
				last_out_q  <= k_last;
				trunc_out_q <= trunc_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_acc && room)
			smp_mem[cnt_q[dlf_pkg::IDX_W-1:0]] <= sample;
		smp_rd_q <= smp_mem[k_q];
	end

	always_ff @(posedge clk) begin
		if (in_acc && room && (cnt_q < dlf_pkg::CNT_W'(2)))
			cau_mem[cnt_q[dlf_pkg::IDX_W-1:0]] <= smp_v;
		else if (state_q == dlf_pkg::S_CWR)
			cau_mem[cnt_q[dlf_pkg::IDX_W-1:0]] <= rnd_v;
		cau_rd_q <= cau_mem[k_q];
	end

	always_ff @(posedge clk) begin
		if ((state_q == dlf_pkg::S_AGET) && edge_k)
			anti_mem[k_q] <= xk_v;
		else if (state_q == dlf_pkg::S_AWR)
			anti_mem[k_q] <= rnd_v;
		anti_rd_q <= anti_mem[k_q];
	end

	assign out_valid      = out_valid_q;
	assign filtered       = filt_q;
	assign last_out       = last_out_q;
	assign line_truncated = trunc_out_q;

endmodule

>>> src/dlf_mac.sv
module dlf_mac (
	input  logic                                    clk,
	input  dlf_pkg::mac_ctrl_t                      ctrl,
	input  logic signed [dlf_pkg::COEF_W-1:0]       coef,
	input  logic signed [dlf_pkg::OPD_W-1:0]        opd,
	output logic signed [dlf_pkg::ACC_W-1:0]        acc
);

	logic signed [dlf_pkg::ACC_W-1:0] acc_q;
	logic signed [dlf_pkg::ACC_W-1:0] prod;

	assign prod = dlf_pkg::ACC_W'(coef * opd);

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			acc_q <= (ctrl.clr ? '0 : acc_q) + prod;
		end
	end

	assign acc = acc_q;

endmodule

>>> src/dlf_checker.sv
module dlf_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [dlf_pkg::SMP_W-1:0]   filtered,
	input logic                               last_out
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(filtered) && $stable(last_out))
		else $error("output item changed while stalled");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is pending");

	a_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_out |=> in_ready && !out_valid)
		else $error("not idle after end of line");

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_out |=> !in_ready)
		else $error("idle in the middle of a line");

endmodule

bind deriche_line_filter dlf_checker u_dlf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.filtered  (filtered),
	.last_out  (last_out)
);

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	typedef struct {
		logic signed [dlf_pkg::SMP_W-1:0] filtered;
		logic                             last;
		logic                             trunc;
	} line_result_t;

	class line_scoreboard;
		logic                              subtract;
		logic signed [dlf_pkg::COEF_W-1:0] coef [8];
		logic signed [dlf_pkg::SMP_W-1:0]  samples [dlf_pkg::LINE_MAX];
		longint                            causal [dlf_pkg::LINE_MAX];
		int                                count;
		bit                                trunc;
		line_result_t                      pending [$];
		int                                mismatches;
		int                                results_seen;
		int                                lines_seen;

		function new();
			subtract = 1'b0;
			coef[dlf_pkg::REG_SUB] = '0;
			coef[dlf_pkg::REG_A0] = '0;
			coef[dlf_pkg::REG_A1] = 18'sd65536;
			coef[dlf_pkg::REG_A2] = 18'sd65536;
			coef[dlf_pkg::REG_A3] = '0;
			coef[dlf_pkg::REG_B1] = '0;
			coef[dlf_pkg::REG_B2] = '0;
			coef[dlf_pkg::REG_GAIN] = 18'sd65536;
			count = 0;
			trunc = 0;
			mismatches = 0;
			results_seen = 0;
			lines_seen = 0;
		endfunction

		function void write_reg(logic [dlf_pkg::REG_IDX_W-1:0] idx,
			logic [dlf_pkg::COEF_W-1:0] data);
			if (idx == dlf_pkg::REG_SUB)
				subtract = data[0];
			else
				coef[idx] = data;
		endfunction

		function longint to_q16(longint acc);
			longint r;
			r = (acc + 32768) >>> 16;
			if (r > 64'sd2147483647) r = 64'sd2147483647;
			if (r < -64'sd2147483648) r = -64'sd2147483648;
			return r;
		endfunction

		function void note_sample(logic signed [dlf_pkg::SMP_W-1:0] x, logic last);
			longint a0, a1, a2, a3, b1, b2, g, im1, im2, v, s, y;
			longint anti [dlf_pkg::LINE_MAX];
			line_result_t r;
			a0 = coef[dlf_pkg::REG_A0]; a1 = coef[dlf_pkg::REG_A1];
			a2 = coef[dlf_pkg::REG_A2]; a3 = coef[dlf_pkg::REG_A3];
			b1 = coef[dlf_pkg::REG_B1]; b2 = coef[dlf_pkg::REG_B2];
			g = coef[dlf_pkg::REG_GAIN];
			if (count < dlf_pkg::LINE_MAX) begin
				samples[count] = x;
				if (count < 2)
					causal[count] = longint'(x) * 65536;
				else
					causal[count] = to_q16((a0 * x + a1 * samples[count-1]) * 65536
						+ b1 * causal[count-1] + b2 * causal[count-2]);
				count++;
			end else
				trunc = 1;
			if (!last)
				return;
			im1 = 0;
			im2 = 0;
			for (int k = count - 1; k >= 0; k--) begin
				if (k + 2 >= count)
					v = longint'(samples[k]) * 65536;
				else
					v = to_q16((a2 * samples[k+1] + a3 * samples[k+2]) * 65536
						+ b1 * im1 + b2 * im2);
				anti[k] = v;
				im2 = im1;
				im1 = v;
			end
			for (int k = 0; k < count; k++) begin
				s = subtract ? causal[k] - anti[k] : causal[k] + anti[k];
				y = (s * g + (64'sd1 <<< 31)) >>> 32;
				if (y > 32767) y = 32767;
				if (y < -32768) y = -32768;
				r.filtered = y[15:0];
				r.last = (k + 1 == count);
				r.trunc = trunc;
				pending.push_back(r);
			end
			lines_seen++;
			count = 0;
			trunc = 0;
		endfunction

		function void check_result(logic signed [dlf_pkg::SMP_W-1:0] f, logic l, logic t);
			line_result_t e;
			results_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result filtered=%0d last=%b trunc=%b", f, l, t);
				return;
			end
			e = pending.pop_front();
			if (e.filtered !== f || e.last !== l || e.trunc !== t) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp %0d/%b/%b got %0d/%b/%b",
						e.filtered, e.last, e.trunc, f, l, t);
			end
		endfunction
	endclass

	logic                              clk = 0;
	logic                              arst_n = 0;
	logic                              in_valid = 0;
	logic                              in_ready;
	logic signed [dlf_pkg::SMP_W-1:0]  sample = '0;
	logic                              last_in_line = 0;
	logic                              out_valid;
	logic                              out_ready = 0;
	logic signed [dlf_pkg::SMP_W-1:0]  filtered;
	logic                              last_out;
	logic                              line_truncated;
	logic                              cfg_we = 0;
	logic [dlf_pkg::REG_IDX_W-1:0]     cfg_index = '0;
	logic [dlf_pkg::COEF_W-1:0]        cfg_data = '0;

	line_scoreboard sb = new();
	bit no_idle = 0;
	int sent = 0;

	always #5 clk = ~clk;

	deriche_line_filter dut (.*);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(filtered, last_out, line_truncated);
		if (arst_n && in_valid && in_ready)
			sb.note_sample(sample, last_in_line);
	end

	always @(negedge clk)
		out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 38);

	// valid stays high between back-to-back items; idle gaps and settle drop it
	task automatic send(logic signed [dlf_pkg::SMP_W-1:0] x, logic l);
		while (!no_idle && $urandom_range(99) < 38) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		sample <= x;
		last_in_line <= l;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic send_line(int n, bit rnd);
		for (int i = 0; i < n; i++)
			send(dlf_pkg::SMP_W'(rnd ? $urandom : ((i % 2) ? 16'sh7fff : 16'sh8000)),
				i == n - 1);
	endtask

	task automatic settle();
		in_valid <= 0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	task automatic write_reg(logic [dlf_pkg::REG_IDX_W-1:0] idx,
		logic [dlf_pkg::COEF_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, data);
	endtask

	task automatic random_config(bit extreme);
		for (int i = 0; i < 8; i++) begin
			if (extreme)
				write_reg(dlf_pkg::REG_IDX_W'(i), $urandom_range(1) ? 18'h1ffff : 18'h20000);
			else if (i >= dlf_pkg::REG_B1 && i <= dlf_pkg::REG_B2)
				write_reg(dlf_pkg::REG_IDX_W'(i),
					dlf_pkg::COEF_W'($urandom_range(32768) - 16384));
			else
				write_reg(dlf_pkg::REG_IDX_W'(i), dlf_pkg::COEF_W'($urandom));
		end
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		send_line(1, 0);
		send_line(2, 0);
		send_line(3, 1);
		send_line(5, 0);
		send(16'sh0000, 1);
		settle();
		write_reg(dlf_pkg::REG_SUB, 0);
		write_reg(dlf_pkg::REG_GAIN, 18'sd32768);
		send_line(4, 1);
		send_line(6, 1);
		settle();
		random_config(1);
		send_line(70, 0);
		send_line(66, 1);
		settle();
		write_reg(dlf_pkg::REG_SUB, 1);
		write_reg(dlf_pkg::REG_A0, 18'sd0);
		write_reg(dlf_pkg::REG_A1, 18'sd65536);
		write_reg(dlf_pkg::REG_A2, 18'sd65536);
		write_reg(dlf_pkg::REG_A3, 18'sd0);
		write_reg(dlf_pkg::REG_B1, 18'sd45000);
		write_reg(dlf_pkg::REG_B2, -18'sd20000);
		write_reg(dlf_pkg::REG_GAIN, 18'sd65536);
		while (sent < 480) begin
			if (sent > 200 && sent < 300)
				no_idle = 1;
			else
				no_idle = 0;
			if ($urandom_range(3) == 0) begin
				settle();
				random_config($urandom_range(4) == 0);
			end
			send_line($urandom_range(9) == 0 ? $urandom_range(60, 68) : $urandom_range(1, 12), 1);
		end
		settle();
		$display("Sent %0d samples in %0d lines, checked %0d filtered results.",
			sent, sb.lines_seen, sb.results_seen);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

endmodule
